// ===== sv/twsu_pkg.sv =====
// ----------------------------------------------------------------------------
// twsu_pkg: shared types and constants of the timing wheel scheduler
// Widths, operation and status codes, queue command and result records.
// ----------------------------------------------------------------------------
`default_nettype none

package twsu_pkg;

  localparam int NUM_SLOTS  = 64;   // power of two: slot math is a mask
  localparam int MAX_TIMERS = 64;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int HANDLE_W   = 6;
  localparam int TURNS_W    = 25;
  localparam int STATUS_W   = 3;
  localparam int TMO_W      = 32;
  localparam int SI_W       = 16;
  localparam int SCAN_W     = $clog2(MAX_TIMERS) + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_ADD  = 2'd0,
    K_NEG  = 2'd1,
    K_DEL  = 2'd2,
    K_TICK = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED    = 3'd0,
    ST_NEG      = 3'd1,
    ST_FULL     = 3'd2,
    ST_DELETED  = 3'd3,
    ST_DEL_FREE = 3'd4,
    ST_EXPIRED  = 3'd5
  } status_t;

  typedef struct packed {
    kind_t                kind;
    logic [TMO_W-2:0]     tmo;
    logic [HANDLE_W-1:0]  handle;
  } cmd_t;

  typedef struct packed {
    status_t              status;
    logic [HANDLE_W-1:0]  entry;
    logic [SLOT_W-1:0]    slot;
    logic [TURNS_W-1:0]   turns;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/twsu_ram.sv =====
// ----------------------------------------------------------------------------
// twsu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twsu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== sv/twsu_front.sv =====
// ----------------------------------------------------------------------------
// twsu_front: input stage
// Takes stream transfers, classifies the operation, drops unknown ops.
// ----------------------------------------------------------------------------
`default_nettype none

module twsu_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [twsu_pkg::IN_DATA_W-1:0] in_tdata,
  input  wire logic [1:0]                     in_tuser,
  output      logic                           cmd_valid,
  output      twsu_pkg::cmd_t                 cmd,
  input  wire logic                           cmd_ready
);

  logic           v_r, v_nxt;
  twsu_pkg::cmd_t cmd_r, cmd_nxt;
  logic           acc;
  logic [twsu_pkg::TMO_W-1:0] tmo;

  assign in_tready = !v_r || cmd_ready;
  assign acc       = in_tvalid && in_tready;
  assign tmo       = in_tdata[twsu_pkg::TMO_W-1:0];
  assign cmd_valid = v_r;
  assign cmd       = cmd_r;

  always_comb begin
    v_nxt   = v_r && !cmd_ready;
    cmd_nxt = cmd_r;
    if (acc) begin
      v_nxt          = 1'b1;
      cmd_nxt.tmo    = tmo[twsu_pkg::TMO_W-2:0];
      cmd_nxt.handle = in_tdata[twsu_pkg::TMO_W +: twsu_pkg::HANDLE_W];
      case (twsu_pkg::op_t'(in_tuser))
        twsu_pkg::OP_ADD:  cmd_nxt.kind = tmo[twsu_pkg::TMO_W-1] ? twsu_pkg::K_NEG
                                                                 : twsu_pkg::K_ADD;
        twsu_pkg::OP_DEL:  cmd_nxt.kind = twsu_pkg::K_DEL;
        twsu_pkg::OP_TICK: cmd_nxt.kind = twsu_pkg::K_TICK;
        default: begin
          // unknown op: no result, no state change
          cmd_nxt.kind = twsu_pkg::K_TICK;
          v_nxt        = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    cmd_r <= cmd_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/twsu_fifo.sv =====
// ----------------------------------------------------------------------------
// twsu_fifo: command queue between front and back
// Small register FIFO of classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module twsu_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  output      logic           push_ready,
  input  wire twsu_pkg::cmd_t push_data,
  output      logic           pop_valid,
  input  wire logic           pop_ready,
  output      twsu_pkg::cmd_t pop_data
);

  twsu_pkg::cmd_t                   mem_r [twsu_pkg::FIFO_DEPTH];
  logic [twsu_pkg::FIFO_AW-1:0]     wp_r, wp_nxt, rp_r, rp_nxt;
  logic [twsu_pkg::FIFO_AW:0]       cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign push_ready = cnt_r != (twsu_pkg::FIFO_AW+1)'(twsu_pkg::FIFO_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop  ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/twsu_div.sv =====
// ----------------------------------------------------------------------------
// twsu_div: restoring divider
// 31-bit unsigned dividend by 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module twsu_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [twsu_pkg::TMO_W-2:0]    dividend,
  input  wire logic [twsu_pkg::SI_W-1:0]     divisor,
  output      logic                          busy,
  output      logic                          done,
  output      logic [twsu_pkg::TMO_W-2:0]    quotient
);

  localparam int QW = twsu_pkg::TMO_W - 1;
  localparam int CW = $clog2(QW);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  logic [QW-1:0]                 q_r, q_nxt;
  logic [twsu_pkg::SI_W-1:0]     rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [twsu_pkg::SI_W:0]       sh, diff;

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;
  assign sh       = {rem_r, q_r[QW-1]};
  assign diff     = sh - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(QW - 1);
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[twsu_pkg::SI_W]) begin
        rem_nxt = diff[twsu_pkg::SI_W-1:0];
        q_nxt   = {q_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[twsu_pkg::SI_W-1:0];
        q_nxt   = {q_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/twsu_back.sv =====
// ----------------------------------------------------------------------------
// twsu_back: timer table engine
// Executes add, delete and tick commands against the timer table.
// ----------------------------------------------------------------------------
`default_nettype none

module twsu_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [twsu_pkg::SI_W-1:0]  slot_interval,
  input  wire logic                       cmd_valid,
  output      logic                       cmd_ready,
  input  wire twsu_pkg::cmd_t             cmd,
  output      logic                       res_valid,
  input  wire logic                       res_ready,
  output      twsu_pkg::res_t             res
);

  localparam int HW = twsu_pkg::HANDLE_W;
  localparam int SW = twsu_pkg::SLOT_W;
  localparam int TW = twsu_pkg::TURNS_W;
  localparam int RW = TW + SW;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ADD  = 6'b000010,
    S_EMIT = 6'b000100,
    S_TRD  = 6'b001000,
    S_TEV  = 6'b010000,
    S_TFIN = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [twsu_pkg::MAX_TIMERS-1:0] used_r, used_nxt;
  logic [SW-1:0]                   cur_r, cur_nxt;
  logic [twsu_pkg::SCAN_W-1:0]     k_r, k_nxt;
  logic [HW-1:0]                   kidx;
  logic                            found_r, found_nxt, qdone_r, qdone_nxt;
  logic [HW-1:0]                   fh_r, fh_nxt, ph_r, ph_nxt;
  logic                            pv_r, pv_nxt;
  twsu_pkg::cmd_t                  c_r, c_nxt;
  twsu_pkg::res_t                  em_r, em_nxt, out_r, out_nxt, ld_data;
  logic                            ov_r, ov_nxt, ld, ofree;
  logic                            div_start, div_busy, div_done;
  logic [twsu_pkg::TMO_W-2:0]      div_q, count;
  logic [twsu_pkg::SI_W-1:0]       dvs;
  logic                            we;
  logic [HW-1:0]                   wa;
  logic [RW-1:0]                   wd, rd;
  logic [TW-1:0]                   rd_turns;
  logic [SW-1:0]                   rd_slot;
  logic                            hit, exp_fire;

  assign kidx      = k_r[HW-1:0];
  assign cmd_ready = state_r == S_IDLE;
  assign res_valid = ov_r;
  assign res       = out_r;
  assign ofree     = !ov_r || res_ready;
  assign dvs       = (slot_interval == '0) ? twsu_pkg::SI_W'(1) : slot_interval;
  assign count     = (div_q == '0) ? (twsu_pkg::TMO_W-1)'(1) : div_q;
  assign rd_turns  = rd[RW-1:SW];
  assign rd_slot   = rd[SW-1:0];
  assign hit       = used_r[kidx] && (rd_slot == cur_r);
  assign exp_fire  = (state_r == S_TEV) && hit && (rd_turns == '0) && (!pv_r || ofree);

  twsu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (c_nxt.tmo),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  twsu_ram #(.WIDTH(RW), .DEPTH(twsu_pkg::MAX_TIMERS)) u_tab (
    .clk     (clk),
    .wr_en   (we),
    .wr_addr (wa),
    .wr_data (wd),
    .rd_addr (kidx),
    .rd_data (rd)
  );

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    cur_nxt   = cur_r;
    k_nxt     = k_r;
    found_nxt = found_r;
    qdone_nxt = qdone_r || div_done;
    fh_nxt    = fh_r;
    ph_nxt    = ph_r;
    pv_nxt    = pv_r;
    c_nxt     = c_r;
    em_nxt    = em_r;
    div_start = 1'b0;
    we        = 1'b0;
    wa        = kidx;
    wd        = rd;
    ld        = 1'b0;
    ld_data   = em_r;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          c_nxt  = cmd;
          em_nxt = '{status: twsu_pkg::ST_NEG, entry: '0, slot: '0, turns: '0,
                     last: 1'b1};
          case (cmd.kind)
            twsu_pkg::K_NEG: state_nxt = S_EMIT;
            twsu_pkg::K_DEL: begin
              if (used_r[cmd.handle]) begin
                used_nxt[cmd.handle] = 1'b0;
                em_nxt.status        = twsu_pkg::ST_DELETED;
                em_nxt.entry         = cmd.handle;
              end else begin
                em_nxt.status = twsu_pkg::ST_DEL_FREE;
              end
              state_nxt = S_EMIT;
            end
            twsu_pkg::K_ADD: begin
              div_start = 1'b1;
              k_nxt     = '0;
              found_nxt = 1'b0;
              qdone_nxt = 1'b0;
              state_nxt = S_ADD;
            end
            default: begin
              k_nxt     = '0;
              pv_nxt    = 1'b0;
              state_nxt = S_TRD;
            end
          endcase
        end
      end

      S_ADD: begin
        // lowest free handle, one entry per cycle, beside the divider
        if (!found_r && !k_r[twsu_pkg::SCAN_W-1]) begin
          if (!used_r[kidx]) begin
            found_nxt = 1'b1;
            fh_nxt    = kidx;
          end
          k_nxt = k_r + 1'b1;
        end
        if (qdone_r && (found_r || k_r[twsu_pkg::SCAN_W-1])) begin
          if (!found_r) begin
            em_nxt.status = twsu_pkg::ST_FULL;
          end else begin
            em_nxt.status = twsu_pkg::ST_ADDED;
            em_nxt.entry  = fh_r;
            em_nxt.slot   = cur_r + count[SW-1:0];
            em_nxt.turns  = count[twsu_pkg::TMO_W-2:SW];
            used_nxt[fh_r] = 1'b1;
            we = 1'b1;
            wa = fh_r;
            wd = {em_nxt.turns, em_nxt.slot};
          end
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (ofree) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_TRD: state_nxt = S_TEV;

      S_TEV: begin
        ld_data = '{status: twsu_pkg::ST_EXPIRED, entry: ph_r, slot: cur_r,
                    turns: '0, last: 1'b0};
        if (hit && rd_turns != '0) begin
          we = 1'b1;
          wd = {rd_turns - 1'b1, rd_slot};
        end
        if (exp_fire) begin
          ld             = pv_r;
          used_nxt[kidx] = 1'b0;
          ph_nxt         = kidx;
          pv_nxt         = 1'b1;
        end
        if (!hit || rd_turns != '0 || exp_fire) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = (kidx == HW'(twsu_pkg::MAX_TIMERS - 1)) ? S_TFIN : S_TRD;
        end
      end

      S_TFIN: begin
        ld_data = '{status: twsu_pkg::ST_EXPIRED, entry: ph_r, slot: cur_r,
                    turns: '0, last: 1'b1};
        if (!pv_r || ofree) begin
          ld        = pv_r;
          pv_nxt    = 1'b0;
          cur_nxt   = cur_r + 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    ov_nxt  = ov_r && !res_ready;
    out_nxt = out_r;
    if (ld) begin
      ov_nxt  = 1'b1;
      out_nxt = ld_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      cur_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
      found_r <= 1'b0;
      qdone_r <= 1'b0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      cur_r   <= cur_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
      found_r <= found_nxt;
      qdone_r <= qdone_nxt;
      k_r     <= k_nxt;
    end
    fh_r  <= fh_nxt;
    ph_r  <= ph_nxt;
    c_r   <= c_nxt;
    em_r  <= em_nxt;
    out_r <= out_nxt;
  end

`ifndef SYNTHESIS
  a_pend_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    pv_r |-> (state_r == S_TRD || state_r == S_TEV || state_r == S_TFIN))
    else $error("pending expiry outside tick scan");

  a_div_in_add: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> state_r == S_ADD)
    else $error("divider busy outside add");

  a_expire_frees: assert property (@(posedge clk) disable iff (!rst_n)
    exp_fire |=> !used_r[$past(kidx)])
    else $error("expired entry still marked used");
`endif

endmodule

`default_nettype wire

// ===== sv/timing_wheel_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// timing_wheel_scheduler_unit: hashed timing wheel, 64 slots, 64 timers
// Input stage, command queue and table engine with output register.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer; in_tuser = op (0 add, 1 delete, 2 tick).
//           Op 3 is dropped without a result.
//   out_* : results; out_tuser = status, out_tlast marks the final result of
//           a command. Add and delete give one result, a tick gives one per
//           expired timer (ascending handle) or none.
//   cfg_* : slot_interval write, only while the block is idle; 0 acts as 1.
// Execution:
//   Add    : waits on the 31-step serial divider.
//   Delete : front register, queue, table engine, then output register.
//   Tick   : per table entry, a registered table read, then an update.
//   One command executes at a time; the 4-entry queue and input register
//   keep taking transfers while the engine works.
// Reset: synchronous, all timers freed, current slot 0, slot_interval 1.
// Stall: a held result blocks the engine; a tick scan waits in place until
//   the output register frees, so nothing is lost or reordered.
// ----------------------------------------------------------------------------
`default_nettype none

module timing_wheel_scheduler_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_tvalid,
  output      logic                            in_tready,
  input  wire logic [twsu_pkg::IN_DATA_W-1:0]  in_tdata,   // timeout[31:0], handle[37:32]
  input  wire logic [1:0]                      in_tuser,   // op
  // result channel
  output      logic                            out_tvalid,
  input  wire logic                            out_tready,
  output      logic [twsu_pkg::OUT_DATA_W-1:0] out_tdata,  // entry, target_slot, turns
  output      logic [twsu_pkg::STATUS_W-1:0]   out_tuser,  // status
  output      logic                            out_tlast,
  // configuration
  input  wire logic                            cfg_wr_en,
  input  wire logic [twsu_pkg::SI_W-1:0]       cfg_wr_data
);

  logic [twsu_pkg::SI_W-1:0] si_r, si_nxt;
  logic                      f_valid, f_ready, q_valid, q_ready;
  twsu_pkg::cmd_t            f_cmd, q_cmd;
  twsu_pkg::res_t            res;

  // slot interval register
  assign si_nxt = cfg_wr_en ? cfg_wr_data : si_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r <= twsu_pkg::SI_W'(1);
    end else begin
      si_r <= si_nxt;
    end
  end

  twsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  twsu_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  twsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .slot_interval (si_r),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .res_valid     (out_tvalid),
    .res_ready     (out_tready),
    .res           (res)
  );

  // tdata: entry [5:0], target_slot [11:6], turns [36:12], zero pad
  assign out_tdata = {3'b000, res.turns, res.slot, res.entry};
  assign out_tuser = res.status;
  assign out_tlast = res.last;

endmodule

`default_nettype wire
